// ===== sv/twt_pkg.sv =====
// Shared constants, types and character helpers for the word tokenizer.
package twt_pkg;

   localparam int WORD_MAX   = 32;
   localparam int BUF_DEPTH  = WORD_MAX - 1;
   localparam int LEN_W      = $clog2(WORD_MAX);
   localparam int ADDR_W     = $clog2(BUF_DEPTH);
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_DASH = 8'h2D;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] ch;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return is_alnum(c) || c == CHAR_DOT || c == CHAR_DASH;
   endfunction

   function automatic logic [7:0] lower_char(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

// ===== sv/twt_if.sv =====
// Valid/ready channel interfaces for the text input and the word output.
interface twt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

interface twt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  word_char;
   logic        word_last;
   logic [31:0] word_count;
   modport source (output valid, output word_char, output word_last, output word_count,
                   input ready);
   modport sink (input valid, input word_char, input word_last, input word_count,
                 output ready);
endinterface

// ===== sv/twt_front.sv =====
// Front end: accepts text bytes, classifies them and issues word commands.
module twt_front (
   input  logic              clock,
   input  logic              reset,
   twt_req_if.sink           req_chan,
   input  logic              fifo_full,
   output logic              push,
   output twt_pkg::cmd_type  push_cmd
);
   import twt_pkg::*;

   logic       in_word_ff;
   logic       in_word_in;
   logic       accept;
   logic [7:0] c;

   assign req_chan.ready = !fifo_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign c              = req_chan.text_byte;

   always_comb begin
      push        = 1'b0;
      push_cmd.op = CMD_APPEND;
      push_cmd.ch = lower_char(c);
      in_word_in  = in_word_ff;
      if (accept) begin
         if (in_word_ff) begin
            push = 1'b1;
            if (!is_word_char(c)) begin
               push_cmd.op = CMD_FINISH;
               in_word_in  = 1'b0;
            end
         end else if (is_alnum(c)) begin
            push        = 1'b1;
            push_cmd.op = CMD_START;
            in_word_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff <= 1'b0;
      end else begin
         in_word_ff <= in_word_in;
      end
   end

endmodule

// ===== sv/twt_cmd_fifo.sv =====
// Short command queue between the front end and the word back end.
module twt_cmd_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  twt_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output twt_pkg::cmd_type          head,
   output twt_pkg::fifo_status_type  status
);
   import twt_pkg::*;

   cmd_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign status.full  = count_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign status.empty = count_ff == '0;
   assign head         = mem_ff[rd_ptr_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/twt_back.sv =====
// Back end: buffers word characters and emits finished words one character per transfer.
module twt_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              keep_long,
   input  logic              fifo_empty,
   input  twt_pkg::cmd_type  head,
   output logic              pop,
   twt_rsp_if.source         rsp_chan,
   output logic [31:0]       word_counter
);
   import twt_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic [7:0]        buf_mem [BUF_DEPTH];
   logic              state_ff, state_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic              full_ff, full_in;
   logic              last_dot_ff, last_dot_in;
   logic [31:0]       counter_ff, counter_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  emit_len_ff, emit_len_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_char_ff;
   logic              rsp_last_ff, rsp_last_in;
   logic [31:0]       rsp_count_ff;
   logic              out_free;
   logic              load;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [LEN_W-1:0]  eff_len;
   logic              eff_full;
   logic [LEN_W-1:0]  new_len;
   logic [LEN_W-1:0]  trimmed;
   logic [LEN_W-1:0]  idx_next;

   assign out_free          = !rsp_valid_ff || rsp_chan.ready;
   assign pop               = (state_ff == ST_IDLE) && !fifo_empty;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.word_char  = rsp_char_ff;
   assign rsp_chan.word_last  = rsp_last_ff;
   assign rsp_chan.word_count = rsp_count_ff;
   assign word_counter      = counter_ff;

   assign eff_len  = (head.op == CMD_START) ? '0 : length_ff;
   assign eff_full = (head.op == CMD_START) ? 1'b0 : full_ff;
   assign new_len  = eff_len + LEN_W'(1);
   assign trimmed  = length_ff - LEN_W'(last_dot_ff);
   assign idx_next = idx_ff + LEN_W'(1);

   always_comb begin
      state_in     = state_ff;
      length_in    = length_ff;
      full_in      = full_ff;
      last_dot_in  = last_dot_ff;
      counter_in   = counter_ff;
      idx_in       = idx_ff;
      emit_len_in  = emit_len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_last_in  = rsp_last_ff;
      load         = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = eff_len[ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               case (head.op)
                  CMD_START, CMD_APPEND: begin
                     length_in = eff_len;
                     full_in   = eff_full;
                     if (eff_len < LEN_W'(BUF_DEPTH)) begin
                        wr_en       = 1'b1;
                        length_in   = new_len;
                        last_dot_in = head.ch == CHAR_DOT;
                        full_in     = eff_full || (new_len == LEN_W'(BUF_DEPTH));
                     end
                  end
                  CMD_FINISH: begin
                     length_in   = '0;
                     full_in     = 1'b0;
                     last_dot_in = 1'b0;
                     if (!(full_ff && !keep_long) && trimmed != '0) begin
                        state_in    = ST_EMIT;
                        idx_in      = '0;
                        emit_len_in = trimmed;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               idx_in       = idx_next;
               rsp_last_in  = idx_next == emit_len_ff;
               if (idx_next == emit_len_ff) begin
                  counter_in = counter_ff + 32'd1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         full_ff      <= 1'b0;
         last_dot_ff  <= 1'b0;
         counter_ff   <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         full_ff      <= full_in;
         last_dot_ff  <= last_dot_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      emit_len_ff <= emit_len_in;
      rsp_last_ff <= rsp_last_in;
      if (load) begin
         rsp_count_ff <= counter_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[wr_addr] <= head.ch;
      end
      if (load) begin
         rsp_char_ff <= buf_mem[idx_ff[ADDR_W-1:0]];
      end
   end

endmodule

// ===== sv/text_word_tokenizer.sv =====
// Top level of the word tokenizer: front end, command queue, back end and control register.
//
//   Channel   Direction  Carries
//   req_chan  in         text_byte, one per transfer
//   rsp_chan  out        word_char, word_last, word_count, one per transfer
//   csr_*     in         keep_long_words, written by csr_wr_en
//
// The front end takes one byte per cycle while the four-entry command queue has room.
// The back end retires one queued command per cycle while idle; a finished word then holds
// it in emission, one character per cycle from the word buffer while the output is free.
// Reset is synchronous and active high; the word number restarts at 1.
// A stalled output holds the back end, the queue fills, and then input ready drops.
module text_word_tokenizer (
   input  logic      clock,
   input  logic      reset,
   twt_req_if.sink   req_chan,
   twt_rsp_if.source rsp_chan,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);
   import twt_pkg::*;

   logic            keep_ff;
   logic            push;
   cmd_type         push_cmd;
   logic            pop;
   cmd_type         head;
   fifo_status_type fifo_st;
   logic [31:0]     word_counter;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= 1'b0;
      end else if (csr_wr_en) begin
         keep_ff <= csr_wr_data;
      end
   end

   twt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .fifo_full (fifo_st.full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   twt_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (fifo_st)
   );

   twt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .keep_long    (keep_ff),
      .fifo_empty   (fifo_st.empty),
      .head         (head),
      .pop          (pop),
      .rsp_chan     (rsp_chan),
      .word_counter (word_counter)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && fifo_st.full))
      else $error("Command pushed into a full queue.");

   a_count_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.word_last)
         |-> word_counter == rsp_chan.word_count + 32'd1)
      else $error("Word number did not advance with the last character.");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.word_last)
         |=> rsp_chan.word_count == $past(rsp_chan.word_count))
      else $error("Word number changed inside a word.");

endmodule

// ===== verif/tb_text_word_tokenizer.sv =====
// Self-checking testbench for text_word_tokenizer: directed and random text with a word predictor.
module tb_text_word_tokenizer;
   import twt_pkg::*;

   typedef struct {
      logic [7:0]  ch;
      logic        last;
      logic [31:0] num;
   } word_char_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   twt_req_if req_chan ();
   twt_rsp_if rsp_chan ();

   text_word_tokenizer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [7:0]    word_buf [BUF_DEPTH];
   int            word_len;
   bit            in_word;
   bit            buf_full;
   logic [31:0]   word_num;
   bit            keep_long;
   bit            idle_on;
   int            fail_count;
   word_char_type pending_word_chars[$];
   word_char_type want;

   always #5 clock = ~clock;

   function automatic bit is_letter_or_digit(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_word_byte(input logic [7:0] c);
      return is_letter_or_digit(c) || c == CHAR_DOT || c == CHAR_DASH;
   endfunction

   function automatic logic [7:0] random_alnum();
      int r;
      r = $urandom_range(0, 61);
      if (r < 10) begin
         return 8'("0" + r);
      end else if (r < 36) begin
         return 8'("A" + r - 10);
      end
      return 8'("a" + r - 36);
   endfunction

   function automatic void buffer_char(input logic [7:0] c);
      if (word_len < BUF_DEPTH) begin
         word_buf[word_len] = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
         word_len++;
      end
      if (word_len >= BUF_DEPTH) begin
         buf_full = 1'b1;
      end
   endfunction

   function automatic void close_word();
      int n;
      bit dropped;
      word_char_type wc;
      n = word_len;
      dropped = buf_full && !keep_long;
      in_word = 1'b0;
      word_len = 0;
      buf_full = 1'b0;
      if (dropped) begin
         return;
      end
      if (n > 0 && word_buf[n - 1] == CHAR_DOT) begin
         n--;
      end
      if (n == 0) begin
         return;
      end
      for (int k = 0; k < n; k++) begin
         wc.ch = word_buf[k];
         wc.last = (k == n - 1);
         wc.num = word_num;
         pending_word_chars.push_back(wc);
      end
      word_num++;
   endfunction

   function automatic void tokenize_byte(input logic [7:0] c);
      if (in_word) begin
         if (is_word_byte(c)) begin
            buffer_char(c);
         end else begin
            close_word();
         end
      end else if (is_letter_or_digit(c)) begin
         in_word = 1'b1;
         word_len = 0;
         buf_full = 1'b0;
         buffer_char(c);
      end
   endfunction

   task automatic send_byte(input logic [7:0] c);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.text_byte <= c;
      do @(posedge clock); while (!req_chan.ready);
      tokenize_byte(c);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   task automatic send_word(input int n_chars, input bit end_dot, input logic [7:0] delim);
      logic [7:0] c;
      for (int i = 0; i < n_chars; i++) begin
         if (i == 0) begin
            c = random_alnum();
         end else if (end_dot && i == n_chars - 1) begin
            c = CHAR_DOT;
         end else if ($urandom_range(0, 7) == 0) begin
            c = $urandom_range(0, 1) ? CHAR_DOT : CHAR_DASH;
         end else begin
            c = random_alnum();
         end
         send_byte(c);
      end
      send_byte(delim);
   endtask

   task automatic write_keep_long(input bit value);
      req_chan.valid <= 1'b0;
      while (pending_word_chars.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      keep_long = value;
   endtask

   task automatic test_char_classes();
      send_text("Az09");
      send_byte(8'hFF);
      send_text("-.am-Z..");
      send_byte(8'h80);
      send_text("Q.");
      send_byte(8'h00);
      send_byte(8'h7F);
      send_text("/:@[`{9");
      send_byte(8'h00);
      send_text("b.");
      send_byte(8'h00);
   endtask

   task automatic test_long_words();
      send_word(BUF_DEPTH - 1, 1'b0, " ");
      send_word(BUF_DEPTH, 1'b0, 8'h00);
      send_word(BUF_DEPTH + 4, 1'b0, ",");
      send_word(BUF_DEPTH, 1'b1, "!");
      send_word(3, 1'b0, 8'h00);
   endtask

   task automatic test_random_text(input int n_items);
      int sent;
      int n;
      logic [7:0] d;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: begin
               n = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 8);
               if ($urandom_range(0, 3) == 0) begin
                  d = 8'h00;
               end else begin
                  do d = 8'($urandom_range(0, 255)); while (is_word_byte(d));
               end
               send_word(n, n > 1 && $urandom_range(0, 3) == 0, d);
               sent += n + 1;
            end
            7, 8: begin
               send_byte(8'($urandom_range(0, 255)));
               sent++;
            end
            default: begin
               send_byte($urandom_range(0, 1) ? CHAR_DOT : CHAR_DASH);
               sent++;
            end
         endcase
      end
      send_byte(8'h00);
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_word_chars.size() == 0) begin
            $error("unexpected transfer: word_char %0h word_count %0d",
                   rsp_chan.word_char, rsp_chan.word_count);
            fail_count++;
         end else begin
            want = pending_word_chars.pop_front();
            if (rsp_chan.word_char !== want.ch) begin
               $error("word_char: expected %0h, actual %0h", want.ch, rsp_chan.word_char);
               fail_count++;
            end
            if (rsp_chan.word_last !== want.last) begin
               $error("word_last: expected %0b, actual %0b", want.last, rsp_chan.word_last);
               fail_count++;
            end
            if (rsp_chan.word_count !== want.num) begin
               $error("word_count: expected %0d, actual %0d", want.num, rsp_chan.word_count);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int waited;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.text_byte = 8'h00;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      word_len = 0;
      in_word = 1'b0;
      buf_full = 1'b0;
      word_num = 32'd1;
      keep_long = 1'b0;
      idle_on = 1'b1;
      fail_count = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_keep_long(1'b0);
      test_char_classes();
      test_long_words();
      write_keep_long(1'b1);
      test_long_words();
      test_random_text(30);
      write_keep_long(1'b0);
      test_random_text(30);
      write_keep_long(1'b1);
      test_random_text(20);
      idle_on = 1'b0;
      write_keep_long(1'b0);
      test_random_text(30);

      req_chan.valid <= 1'b0;
      waited = 0;
      while (pending_word_chars.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (60) @(negedge clock);
      if (pending_word_chars.size() != 0) begin
         $error("%0d word characters never arrived", pending_word_chars.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== text_word_tokenizer.f =====
sv/twt_pkg.sv
sv/twt_if.sv
sv/twt_front.sv
sv/twt_cmd_fifo.sv
sv/twt_back.sv
sv/text_word_tokenizer.sv
verif/tb_text_word_tokenizer.sv
